// ----- sv/text_line_folder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the line folder
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_FOLDER_MACROS_SVH
`define TEXT_LINE_FOLDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tlf_pkg.sv -----
// ----------------------------------------------------------------------------
// Line folder package
// Shared constants, character codes and the cell control bundle.
// ----------------------------------------------------------------------------
package tlf_pkg;

  // Default line length in characters.
  localparam int LINE_LEN_DEF = 32;

  // Reset value of the tab width register.
  localparam logic [3:0] TAB_W_RST = 4'd2;

  // Character codes.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Control bundle broadcast to every cell of the line chain.
  typedef struct packed {
    logic shift;    // every cell takes its right neighbor's byte
    logic wr_char;  // the cell at the fill position takes the input byte
    logic wr_tab;   // cells from fill up to the tab end take a blank
  } cell_ctl_t;

endpackage

// ----- sv/tlf_cell.sv -----
// ----------------------------------------------------------------------------
// Line folder cell
// Holds one character of the line buffer and passes it to its left neighbor.
// ----------------------------------------------------------------------------
module tlf_cell #(
  parameter int LINE_LEN = tlf_pkg::LINE_LEN_DEF,
  parameter int IDX      = 0
) (
  input  logic                             clk,
  input  tlf_pkg::cell_ctl_t               ctl,
  input  logic [7:0]                       char_i,
  input  logic [$clog2(LINE_LEN+1)-1:0]    fill_i,
  input  logic [$clog2(LINE_LEN+1)-1:0]    tab_end_i,
  input  logic [7:0]                       right_i,
  output logic [7:0]                       data_o
);

  localparam int CW = $clog2(LINE_LEN + 1);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  // Shift has priority; writes land only at this cell's own position.
  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = right_i;
    end else if (ctl.wr_char && (fill_i == MY_IDX)) begin
      data_nxt = char_i;
    end else if (ctl.wr_tab && (MY_IDX >= fill_i) && (MY_IDX < tab_end_i)) begin
      data_nxt = tlf_pkg::CH_SP;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ----- sv/text_line_folder.sv -----
// ----------------------------------------------------------------------------
// Text line folder
// Folds a character stream into lines of at most LINE_LEN characters.
// ----------------------------------------------------------------------------
// The line buffer is a chain of LINE_LEN cells; characters leave it through
// cell 0, one per cycle while the output side takes them, as the chain
// shifts left. An ordinary character or a tab that fits leaves the block
// idle, and the next character is accepted in the following cycle. A
// newline or a tab that does not fit emits nothing when the buffer is empty.
// Otherwise a newline, a tab that does not fit, or a character that fills
// the line flushes n characters (the whole line, or the line up to its last
// blank): the block emits the characters, then the newline, one per cycle
// while the output side takes them, and accepts no new character until it
// is back in idle. A fold that leaves characters behind passes through a
// skip state to settle the new fill count; the cut follows the last blank,
// so no blank is left to skip. The output register lets the last result
// wait while the block returns to idle.
module text_line_folder #(
  parameter int LINE_LEN = tlf_pkg::LINE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  localparam int CW = $clog2(LINE_LEN + 1);
  localparam int SW = ((CW > 4) ? CW : 4) + 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(LINE_LEN - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LINE_LEN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_NL,
    ST_SKIP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      lb_r, lb_nxt;        // last blank at index >= 1, 0 if none
  logic [CW-1:0]      emit_cnt_r, emit_cnt_nxt;
  logic [CW-1:0]      remain_r, remain_nxt;
  logic [3:0]         tab_w_r, tab_w_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  tlf_pkg::cell_ctl_t ctl;
  logic [SW-1:0]      tab_sum;
  logic [CW-1:0]      tab_end;
  logic               tab_room;
  logic               slot_free;
  logic               in_xfer;
  logic [CW-1:0]      lb_fold;
  logic [CW-1:0]      cut;
  logic [7:0]         cell_q [LINE_LEN];

  // Cell chain holding the line buffer.
  for (genvar i = 0; i < LINE_LEN; i++) begin : g_cell
    logic [7:0] right;
    if (i == LINE_LEN - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cell_q[i+1];
    end
    tlf_cell #(
      .LINE_LEN (LINE_LEN),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .char_i    (in_char),
      .fill_i    (fill_r),
      .tab_end_i (tab_end),
      .right_i   (right),
      .data_o    (cell_q[i])
    );
  end

  // Tab room check and the position just past the expanded blanks.
  assign tab_sum  = SW'(fill_r) + SW'(tab_w_r);
  assign tab_room = tab_sum < SW'(LINE_LEN);
  assign tab_end  = tab_sum[CW-1:0];

  // Cut point of a fold: after the last blank, or the whole line.
  assign lb_fold = (in_char == tlf_pkg::CH_SP) ? LAST_IDX : lb_r;
  assign cut     = (lb_fold != '0) ? (lb_fold + CW'(1)) : FULL_CNT;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Sequencer: buffer writes, line emission and blank skipping.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    lb_nxt        = lb_r;
    emit_cnt_nxt  = emit_cnt_r;
    remain_nxt    = remain_r;
    tab_w_nxt     = cfg_we ? cfg_wdata : tab_w_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((in_char == tlf_pkg::CH_TAB) && tab_room) begin
            // Expand the tab in place.
            ctl.wr_tab = 1'b1;
            fill_nxt   = tab_end;
            if ((tab_w_r != '0) && (tab_end >= CW'(2))) begin
              lb_nxt = tab_end - CW'(1);
            end
          end else if ((in_char == tlf_pkg::CH_TAB) || (in_char == tlf_pkg::CH_NL)) begin
            // Flush the buffered line, if any.
            if (fill_r != '0) begin
              emit_cnt_nxt = fill_r;
              remain_nxt   = '0;
              state_nxt    = ST_EMIT;
            end
            fill_nxt = '0;
            lb_nxt   = '0;
          end else begin
            ctl.wr_char = 1'b1;
            if (fill_r == LAST_IDX) begin
              // The line is full: fold it.
              emit_cnt_nxt = cut;
              remain_nxt   = FULL_CNT - cut;
              state_nxt    = ST_EMIT;
            end else begin
              fill_nxt = fill_r + CW'(1);
              if ((in_char == tlf_pkg::CH_SP) && (fill_r != '0)) begin
                lb_nxt = fill_r;
              end
            end
          end
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          ctl.shift     = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = cell_q[0];
          out_last_nxt  = 1'b0;
          emit_cnt_nxt  = emit_cnt_r - CW'(1);
          if (emit_cnt_r == CW'(1)) begin
            state_nxt = ST_NL;
          end
        end
      end

      ST_NL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = tlf_pkg::CH_NL;
          out_last_nxt  = 1'b1;
          lb_nxt        = '0;
          if (remain_r == '0) begin
            fill_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SKIP;
          end
        end
      end

      ST_SKIP: begin
        // Drop blanks after the cut; the rest is already at the front.
        if ((remain_r != '0) && (cell_q[0] == tlf_pkg::CH_SP)) begin
          ctl.shift  = 1'b1;
          remain_nxt = remain_r - CW'(1);
        end else begin
          fill_nxt  = remain_r;
          lb_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      lb_r        <= '0;
      emit_cnt_r  <= '0;
      remain_r    <= '0;
      tab_w_r     <= tlf_pkg::TAB_W_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      lb_r        <= lb_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      remain_r    <= remain_nxt;
      tab_w_r     <= tab_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // Assertions.
  `include "text_line_folder_macros.svh"

  `TLF_ASSERT_SAME(a_fill_bound, state_r == ST_IDLE, fill_r < FULL_CNT, "fill count out of range")
  `TLF_ASSERT_SAME(a_emit_cnt, state_r == ST_EMIT, emit_cnt_r != '0, "emit with zero count")
  `TLF_ASSERT_SAME(a_last_nl, out_valid_r && out_last_r, out_char_r == tlf_pkg::CH_NL, "last not a newline")
  `TLF_ASSERT_NEXT(a_nl_last, (state_r == ST_NL) && slot_free, out_valid_r && out_last_r, "newline lost")

endmodule

// ----- tb/text_line_folder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the text line folder
// Streams characters into the folder with random input gaps and output
// back-pressure and checks every output character and its last flag against a
// behavioral model of the line buffer. The run walks through several tab
// widths, including 0 and 15, and covers folds with and without a blank,
// a blank in the last slot, tabs with and without room, and empty lines.
// ----------------------------------------------------------------------------
module text_line_folder_tb;

  localparam int LINE_LEN      = tlf_pkg::LINE_LEN_DEF;
  localparam int SETTLE_CYCLES = 3 * tlf_pkg::LINE_LEN_DEF;
  localparam int PHASE_ITEMS   = 50;

  // One expected output transfer.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fold_out_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_char   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_last;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = 4'h0;

  // Characters waiting to be sent and folded characters waiting to arrive.
  logic [7:0] char_q[$];
  fold_out_t  fold_out_q[$];

  // Model state of the line buffer.
  logic [7:0] line_buf [LINE_LEN];
  int         fill_cnt = 0;
  logic [3:0] tab_w    = tlf_pkg::TAB_W_RST;
  logic [7:0] line_out_q[$];

  // When set, neither side idles.
  bit calm = 1'b0;

  int pushed_count   = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int error_count    = 0;
  int width_settings = 1;

  text_line_folder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout at %0t with %0d folded characters outstanding", $time,
             fold_out_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Append the first len buffered characters and, if len is nonzero, a closing newline.
  task automatic flush_line(input int len);
    int i;
    for (i = 0; i < len; i++) line_out_q.push_back(line_buf[i]);
    if (len > 0) line_out_q.push_back(tlf_pkg::CH_NL);
  endtask

  // Advance the line buffer by one character and queue what it folds out.
  task automatic fold_step(input logic [7:0] c);
    int        i, p, cut, src, dst;
    fold_out_t r;
    line_out_q.delete();
    if (fill_cnt >= LINE_LEN) fill_cnt = 0;
    if (c == tlf_pkg::CH_TAB) begin
      if (fill_cnt + int'(tab_w) < LINE_LEN) begin
        for (i = 0; i < int'(tab_w); i++) begin
          line_buf[fill_cnt] = tlf_pkg::CH_SP;
          fill_cnt++;
        end
      end else begin
        flush_line(fill_cnt);
        fill_cnt = 0;
      end
    end else if (c == tlf_pkg::CH_NL) begin
      flush_line(fill_cnt);
      fill_cnt = 0;
    end else begin
      line_buf[fill_cnt] = c;
      fill_cnt++;
      if (fill_cnt >= LINE_LEN) begin
        // Cut after the last blank past slot 0, or take the whole line.
        cut = LINE_LEN;
        p = LINE_LEN - 1;
        while (p > 0 && line_buf[p] != tlf_pkg::CH_SP) p--;
        if (p > 0) cut = p + 1;
        flush_line(cut);
        src = cut;
        while (src < LINE_LEN && line_buf[src] == tlf_pkg::CH_SP) src++;
        dst = 0;
        while (src < LINE_LEN) begin
          line_buf[dst] = line_buf[src];
          dst++;
          src++;
        end
        fill_cnt = dst;
      end
    end
    for (i = 0; i < line_out_q.size(); i++) begin
      r.ch   = line_out_q[i];
      r.last = (i == line_out_q.size() - 1);
      fold_out_q.push_back(r);
    end
  endtask

  // Input driver: holds each character until its transfer completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fold_step(in_char);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
          in_valid <= 1'b1;
          in_char  <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // Output monitor: compares each transfer with the oldest expectation.
  always @(posedge clk) begin : monitor
    fold_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (fold_out_q.size() == 0) begin
        $display("%0t: unexpected output, expected none, got char %h last %b",
                 $time, out_char, out_last);
        error_count++;
      end else begin
        exp_r = fold_out_q.pop_front();
        if (out_char !== exp_r.ch) begin
          $display("%0t: out_char mismatch, expected %h, got %h", $time,
                   exp_r.ch, out_char);
          error_count++;
        end
        if (out_last !== exp_r.last) begin
          $display("%0t: out_last mismatch, expected %b, got %b", $time,
                   exp_r.last, out_last);
          error_count++;
        end
        checked_count++;
      end
    end
  end

  task automatic push_char(input logic [7:0] c);
    char_q.push_back(c);
    pushed_count++;
  endtask

  // A run of printable characters without any blank.
  task automatic push_word(input int len);
    repeat (len) push_char(8'($urandom_range(8'h21, 8'h7E)));
  endtask

  // Random text: mostly words and whole lines, with some corner lines and noise.
  task automatic push_text(input int target);
    int n0, kind, w, nwords;
    n0 = pushed_count;
    while (pushed_count - n0 < target) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1, 2, 3, 4: begin
          nwords = $urandom_range(2, 8);
          for (w = 0; w < nwords; w++) begin
            push_word($urandom_range(1, 9));
            if ($urandom_range(4) == 0) push_char(tlf_pkg::CH_TAB);
            else push_char(tlf_pkg::CH_SP);
            if ($urandom_range(5) == 0) push_char(tlf_pkg::CH_SP);
          end
          if ($urandom_range(1) == 1) push_char(tlf_pkg::CH_NL);
        end
        5: begin
          // Overlong word: fold without a blank.
          push_char(tlf_pkg::CH_NL);
          push_word($urandom_range(LINE_LEN, LINE_LEN + 8));
        end
        6: begin
          // The only blank sits in slot 0.
          push_char(tlf_pkg::CH_NL);
          push_char(tlf_pkg::CH_SP);
          push_word(LINE_LEN - 1 + $urandom_range(0, 3));
        end
        7: begin
          // The line fills up with a blank in its last slot.
          push_char(tlf_pkg::CH_NL);
          push_word(LINE_LEN - 1);
          push_char(tlf_pkg::CH_SP);
        end
        8: begin
          // A tab near the end of the line, with or without room.
          push_char(tlf_pkg::CH_NL);
          push_word($urandom_range(LINE_LEN - 17, LINE_LEN - 1));
          push_char(tlf_pkg::CH_TAB);
        end
        9: begin
          push_char(tlf_pkg::CH_NL);
          push_char(tlf_pkg::CH_NL);
        end
        default: begin
          repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Wait until every character is taken and every folded character is back,
  // then give the block time to finish any work that emits nothing.
  task automatic wait_drained();
    while (accepted_count != pushed_count || fold_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tab_width(input logic [3:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    tab_w = w;
    width_settings++;
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Short directed stream at the reset tab width: empty lines, extreme
    // bytes, a tab with room, and newlines that flush a short line.
    push_char(tlf_pkg::CH_NL);
    push_char(8'h00);
    push_char(8'hFF);
    push_char(tlf_pkg::CH_SP);
    push_char(tlf_pkg::CH_TAB);
    push_char(8'h41);
    push_char(tlf_pkg::CH_NL);
    push_char(tlf_pkg::CH_NL);
    push_char(8'h7F);
    push_char(8'h80);
    push_char(tlf_pkg::CH_TAB);
    push_char(tlf_pkg::CH_SP);
    push_char(8'h55);
    push_char(8'hAA);
    push_char(tlf_pkg::CH_NL);
    push_text(PHASE_ITEMS);
    wait_drained();

    // Tabs dropped entirely, then the widest tab, then a one-blank tab.
    set_tab_width(4'd0);
    push_text(PHASE_ITEMS);
    wait_drained();
    set_tab_width(4'd15);
    push_text(PHASE_ITEMS);
    wait_drained();
    set_tab_width(4'd1);
    push_text(PHASE_ITEMS);
    wait_drained();

    // A stretch at full rate on both sides.
    calm = 1'b1;
    set_tab_width(4'd8);
    push_text(PHASE_ITEMS);
    wait_drained();
    calm = 1'b0;

    set_tab_width(4'($urandom_range(3, 7)));
    push_text(PHASE_ITEMS);
    wait_drained();

    if (fold_out_q.size() != 0) begin
      $display("%0t: %0d folded characters never arrived", $time, fold_out_q.size());
      error_count++;
    end
    $display("Sent %0d characters over %0d tab widths (0 and 15 included);",
             accepted_count, width_settings);
    $display("checked %0d output characters, %0d errors.", checked_count, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
